// ===== src/lbp_pkg.sv =====
// lbp_pkg: shared constants, codes and types for the lsb-first bit packer
// no dependencies; used by lsb_first_bit_packer and its bench
`default_nettype none

package lbp_pkg;

   localparam int BUFFER_BYTES_DEF = 16;
   localparam int MODE_W           = 3;
   localparam int DATA_W           = 64;
   localparam int BYTE_W           = 8;
   localparam int LEFT_W           = 4;

   localparam logic [MODE_W-1:0] MODE_BIT    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_BYTE   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WORD16 = 3'd2;
   localparam logic [MODE_W-1:0] MODE_WORD32 = 3'd3;
   localparam logic [MODE_W-1:0] MODE_WORD64 = 3'd4;
   localparam logic [MODE_W-1:0] MODE_FLUSH  = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WORK,
      ST_DR_READ,
      ST_DR_OUT
   } state_type;

   function automatic logic [LEFT_W-1:0] mode_bytes(input logic [MODE_W-1:0] mode);
      logic [LEFT_W-1:0] n;
      case (mode)
         MODE_BYTE:   n = 4'd1;
         MODE_WORD16: n = 4'd2;
         MODE_WORD32: n = 4'd4;
         MODE_WORD64: n = 4'd8;
         default:     n = 4'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== src/lsb_first_bit_packer.sv =====
// lsb_first_bit_packer: packs bits, bytes and words lsb first into a byte store
// depends on lbp_pkg; the store is a synchronous memory inside this module
// a transfer is worked on from the cycle after it is taken
// bit and flush items go one per cycle, bytes of a byte or word one per cycle,
// until a drain: it reads each byte, sends it as rsp allows, then resumes the item
// reset clears position, partial byte and control; the memory needs no clearing
`default_nettype none

module lsb_first_bit_packer #(
   parameter int BUFFER_BYTES = lbp_pkg::BUFFER_BYTES_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire  [lbp_pkg::MODE_W-1:0]   req_mode,
   input  wire  [lbp_pkg::DATA_W-1:0]   req_data_value,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [lbp_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                         rsp_last_of_drain
);

   localparam int IDX_W = $clog2(BUFFER_BYTES);
   localparam int POS_W = $clog2(8 * BUFFER_BYTES + 1);
   localparam int CNT_W = POS_W - 3;
   localparam logic [POS_W-1:0] POS_FULL  = POS_W'(8 * BUFFER_BYTES);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(8 * (BUFFER_BYTES - 1));

   // byte store
   logic [7:0] mem [BUFFER_BYTES];
   logic [7:0] mem_q_ff;
   logic       wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [7:0] wr_data;

   lbp_pkg::state_type state_ff, state_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [7:0]        acc_ff, acc_in;
   logic [lbp_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [lbp_pkg::DATA_W-1:0] data_ff, data_in;
   logic [lbp_pkg::LEFT_W-1:0] left_ff, left_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_take;
   logic              done_w;
   logic              need_drain;
   logic              slot_free;
   logic              load_w;
   logic              last_w;
   logic [2:0]        off;
   logic [CNT_W-1:0]  full_cnt;
   logic [CNT_W-1:0]  total_cnt;
   logic [15:0]       merged;
   logic [7:0]        bit_acc;

   assign off       = pos_ff[2:0];
   assign full_cnt  = pos_ff[POS_W-1:3];
   assign total_cnt = full_cnt + CNT_W'(off != 3'd0);
   assign merged    = {8'd0, acc_ff} | ({8'd0, data_ff[7:0]} << off);
   assign bit_acc   = acc_ff | (8'(data_ff[0]) << off);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign last_w    = (CNT_W'(rd_idx_ff) + CNT_W'(1)) == total_cnt;
   assign load_w    = (state_ff == lbp_pkg::ST_DR_OUT) && slot_free;

   // work-state decisions
   always_comb begin
      need_drain = 1'b0;
      done_w     = 1'b0;
      if (state_ff == lbp_pkg::ST_WORK) begin
         case (mode_ff)
            lbp_pkg::MODE_BIT: begin
               need_drain = (pos_ff == POS_FULL);
               done_w     = !need_drain;
            end
            lbp_pkg::MODE_BYTE, lbp_pkg::MODE_WORD16,
            lbp_pkg::MODE_WORD32, lbp_pkg::MODE_WORD64: begin
               need_drain = (pos_ff > POS_LIMIT);
               done_w     = !need_drain && (left_ff == lbp_pkg::LEFT_W'(1));
            end
            lbp_pkg::MODE_FLUSH: begin
               need_drain = (pos_ff != '0);
               done_w     = !need_drain;
            end
            default: begin
               done_w = 1'b1;
            end
         endcase
      end
   end

   assign req_stall = !((state_ff == lbp_pkg::ST_IDLE) || done_w);
   assign req_take  = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lbp_pkg::ST_IDLE: begin
            if (req_take) state_in = lbp_pkg::ST_WORK;
         end
         lbp_pkg::ST_WORK: begin
            if (need_drain) begin
               state_in = lbp_pkg::ST_DR_READ;
            end else if (done_w && !req_take) begin
               state_in = lbp_pkg::ST_IDLE;
            end
         end
         lbp_pkg::ST_DR_READ: begin
            state_in = lbp_pkg::ST_DR_OUT;
         end
         lbp_pkg::ST_DR_OUT: begin
            if (load_w) state_in = last_w ? lbp_pkg::ST_WORK : lbp_pkg::ST_DR_READ;
         end
         default: begin
            state_in = lbp_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      mode_in      = mode_ff;
      data_in      = data_ff;
      left_in      = left_ff;
      rd_idx_in    = rd_idx_ff;
      wr_en        = 1'b0;
      wr_idx       = pos_ff[IDX_W+2:3];
      wr_data      = merged[7:0];
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         lbp_pkg::ST_WORK: begin
            if (need_drain) begin
               rd_idx_in = '0;
            end else begin
               case (mode_ff)
                  lbp_pkg::MODE_BIT: begin
                     pos_in = pos_ff + POS_W'(1);
                     if (off == 3'd7) begin
                        wr_en   = 1'b1;
                        wr_data = bit_acc;
                        acc_in  = 8'd0;
                     end else begin
                        acc_in = bit_acc;
                     end
                  end
                  lbp_pkg::MODE_BYTE, lbp_pkg::MODE_WORD16,
                  lbp_pkg::MODE_WORD32, lbp_pkg::MODE_WORD64: begin
                     wr_en   = 1'b1;
                     acc_in  = merged[15:8];
                     pos_in  = pos_ff + POS_W'(8);
                     data_in = data_ff >> 8;
                     left_in = left_ff - lbp_pkg::LEFT_W'(1);
                  end
                  default: begin
                  end
               endcase
            end
         end
         lbp_pkg::ST_DR_OUT: begin
            if (load_w) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = (CNT_W'(rd_idx_ff) < full_cnt) ? mem_q_ff : acc_ff;
               rsp_last_in  = last_w;
               if (last_w) begin
                  pos_in = '0;
                  acc_in = 8'd0;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
         end
      endcase

      if (req_take) begin
         mode_in = req_mode;
         data_in = req_data_value;
         left_in = lbp_pkg::mode_bytes(req_mode);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_idx] <= wr_data;
      mem_q_ff <= mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbp_pkg::ST_IDLE;
         pos_ff       <= '0;
         acc_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      data_ff     <= data_in;
      left_ff     <= left_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_last_of_drain = rsp_last_ff;

   // position never passes the end of the store
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_FULL)
      else $error("bit position past end of store");

   // no request transfer while a drain is running
   a_drain_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lbp_pkg::ST_DR_READ || state_ff == lbp_pkg::ST_DR_OUT) |-> req_stall)
      else $error("request taken during drain");

   // the final drained byte leaves an empty store
   a_drain_clear: assert property (@(posedge clock) disable iff (reset)
      (load_w && last_w) |=> (pos_ff == '0 && rsp_last_of_drain && rsp_valid))
      else $error("store not cleared after drain");

   // a drain only starts with something in the store
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      need_drain |-> (pos_ff != '0))
      else $error("drain of empty store");

endmodule

`default_nettype wire

// ===== bench/lsb_first_bit_packer_tb.sv =====
// lsb_first_bit_packer_tb: self-checking bench for the lsb-first bit packer
// runs a directed table, a back-pressure burst and random bursts against an in-bench predictor
// depends on lbp_pkg and lsb_first_bit_packer
`default_nettype none

module lsb_first_bit_packer_tb;

   localparam int BUF_BYTES     = lbp_pkg::BUFFER_BYTES_DEF;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int PRESS_ITEMS   = 40;
   localparam int RANDOM_ITEMS  = 95;
   localparam int DIR_ROWS      = 25;
   localparam int USE_MODEL     = -1;
   localparam longint LIMIT_TIME = 5_000_000;

   localparam logic [lbp_pkg::MODE_W-1:0] MODE_SPARE6 = 3'd6;
   localparam logic [lbp_pkg::MODE_W-1:0] MODE_SPARE7 = 3'd7;
   localparam logic [lbp_pkg::DATA_W-1:0] ALL_ONES    = {lbp_pkg::DATA_W{1'b1}};

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_kind_type;
   typedef enum int {MIX_ANY, MIX_BITS, MIX_WIDE} mix_type;

   typedef struct packed {
      logic [lbp_pkg::BYTE_W-1:0] out_byte;
      logic                       last_of_drain;
   } drained_byte_type;

   typedef struct packed {
      logic [lbp_pkg::MODE_W-1:0] mode;
      logic [lbp_pkg::DATA_W-1:0] data;
      int                         exp_n;
      logic [lbp_pkg::BYTE_W-1:0] exp_byte;
   } stim_row_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [lbp_pkg::MODE_W-1:0]   req_mode;
   logic [lbp_pkg::DATA_W-1:0]   req_data_value;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [lbp_pkg::BYTE_W-1:0]   rsp_out_byte;
   logic                         rsp_last_of_drain;

   // predictor state
   logic [lbp_pkg::BYTE_W-1:0] shadow_store [BUF_BYTES] = '{default: '0};
   int                         shadow_pos = 0;
   drained_byte_type           step_bytes [$];
   drained_byte_type           pending_bytes [$];

   int                         row_exp_n = USE_MODEL;
   logic [lbp_pkg::BYTE_W-1:0] row_exp_byte = '0;
   logic                       hold_req = 1'b0;
   logic                       hold_done = 1'b0;

   int fail_count     = 0;
   int items_taken    = 0;
   int bytes_checked  = 0;
   int drains_seen    = 0;
   int full_drains    = 0;
   int bytes_in_drain = 0;

   // directed stimulus; exp_n of USE_MODEL means the predictor decides
   stim_row_type stim_table [DIR_ROWS] = '{
      '{lbp_pkg::MODE_FLUSH,  64'd0,                  0,         8'h00},
      '{MODE_SPARE6,          ALL_ONES,               0,         8'h00},
      '{MODE_SPARE7,          64'd0,                  0,         8'h00},
      '{lbp_pkg::MODE_BYTE,   64'hFF,                 0,         8'h00},
      '{lbp_pkg::MODE_FLUSH,  64'd0,                  1,         8'hFF},
      '{lbp_pkg::MODE_BIT,    ALL_ONES,               0,         8'h00},
      '{lbp_pkg::MODE_FLUSH,  64'd0,                  1,         8'h01},
      '{lbp_pkg::MODE_BIT,    64'hFFFF_FFFF_FFFF_FFFE, 0,         8'h00},
      '{lbp_pkg::MODE_FLUSH,  ALL_ONES,               1,         8'h00},
      '{lbp_pkg::MODE_WORD64, ALL_ONES,               0,         8'h00},
      '{lbp_pkg::MODE_WORD64, ALL_ONES,               0,         8'h00},
      '{lbp_pkg::MODE_BIT,    64'd1,                  BUF_BYTES, 8'hFF},
      '{lbp_pkg::MODE_FLUSH,  64'd0,                  1,         8'h01},
      '{lbp_pkg::MODE_WORD64, 64'h0123_4567_89AB_CDEF, USE_MODEL, 8'h00},
      '{lbp_pkg::MODE_WORD32, 64'hFFFF_FFFF_89AB_CDEF, USE_MODEL, 8'h00},
      '{lbp_pkg::MODE_WORD16, 64'h8000_0000_0000_BEEF, USE_MODEL, 8'h00},
      '{lbp_pkg::MODE_BYTE,   64'hFFFF_FFFF_FFFF_FF5A, USE_MODEL, 8'h00},
      '{lbp_pkg::MODE_BYTE,   64'd0,                  USE_MODEL, 8'h00},
      '{lbp_pkg::MODE_BYTE,   64'hC3,                 USE_MODEL, 8'h00},
      '{lbp_pkg::MODE_WORD64, 64'd0,                  USE_MODEL, 8'h00},
      '{lbp_pkg::MODE_WORD32, 64'h1234_5678,          USE_MODEL, 8'h00},
      '{lbp_pkg::MODE_WORD16, 64'hA55A,               USE_MODEL, 8'h00},
      '{lbp_pkg::MODE_BIT,    64'd1,                  USE_MODEL, 8'h00},
      '{lbp_pkg::MODE_WORD16, 64'h00FF,               USE_MODEL, 8'h00},
      '{lbp_pkg::MODE_FLUSH,  64'd0,                  USE_MODEL, 8'h00}
   };

   lsb_first_bit_packer i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_data_value    (req_data_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_drain (rsp_last_of_drain)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic void pack_drain();
      int n;
      if (shadow_pos == 0) return;
      n = (shadow_pos + 7) / 8;
      if (n > BUF_BYTES) n = BUF_BYTES;
      for (int i = 0; i < n; i++) begin
         step_bytes.push_back('{shadow_store[i], i == n - 1});
      end
      foreach (shadow_store[j]) shadow_store[j] = '0;
      shadow_pos = 0;
   endfunction

   function automatic void pack_bit(input logic b);
      int idx;
      idx = shadow_pos >> 3;
      if (idx < BUF_BYTES) begin
         if (b) shadow_store[idx][shadow_pos % 8] = 1'b1;
         shadow_pos++;
      end
   endfunction

   function automatic void pack_byte(input logic [lbp_pkg::BYTE_W-1:0] v);
      if (shadow_pos > 8 * (BUF_BYTES - 1)) pack_drain();
      for (int i = 0; i < lbp_pkg::BYTE_W; i++) pack_bit(v[i]);
   endfunction

   function automatic void pack_step(input logic [lbp_pkg::MODE_W-1:0] mode,
                                     input logic [lbp_pkg::DATA_W-1:0] data);
      int nbytes;
      nbytes = 0;
      case (mode)
         lbp_pkg::MODE_BIT: begin
            if (shadow_pos >= 8 * BUF_BYTES) pack_drain();
            pack_bit(data[0]);
         end
         lbp_pkg::MODE_BYTE:   nbytes = 1;
         lbp_pkg::MODE_WORD16: nbytes = 2;
         lbp_pkg::MODE_WORD32: nbytes = 4;
         lbp_pkg::MODE_WORD64: nbytes = 8;
         lbp_pkg::MODE_FLUSH:  pack_drain();
         default: ;
      endcase
      for (int i = 0; i < nbytes; i++) pack_byte(data[8*i +: 8]);
   endfunction

   // predict on each req transfer, check each rsp transfer
   always @(posedge clock) begin : watch
      drained_byte_type want;
      if (!reset && req_valid && !req_stall) begin
         step_bytes.delete();
         pack_step(req_mode, req_data_value);
         if (row_exp_n == USE_MODEL) begin
            foreach (step_bytes[i]) pending_bytes.push_back(step_bytes[i]);
         end else begin
            for (int k = 0; k < row_exp_n; k++) begin
               pending_bytes.push_back('{row_exp_byte, k == row_exp_n - 1});
            end
         end
         items_taken++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bytes.size() == 0) begin
            $error("rsp transfer with nothing expected: out_byte %02h last_of_drain %0b",
                   rsp_out_byte, rsp_last_of_drain);
            fail_count++;
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_out_byte);
               fail_count++;
            end
            if (rsp_last_of_drain !== want.last_of_drain) begin
               $error("last_of_drain: expected %0b, got %0b",
                      want.last_of_drain, rsp_last_of_drain);
               fail_count++;
            end
         end
         bytes_checked++;
         bytes_in_drain++;
         if (rsp_last_of_drain === 1'b1) begin
            drains_seen++;
            if (bytes_in_drain == BUF_BYTES) full_drains++;
            bytes_in_drain = 0;
         end
      end
   end

   // receiver: segments of different stall patterns, plus one long hold on request
   initial begin : rsp_pattern
      int             seg_len;
      int             period;
      stall_kind_type kind;
      rsp_stall = 1'b0;
      forever begin
         seg_len = $urandom_range(8, 60);
         period  = $urandom_range(2, 5);
         kind    = stall_kind_type'($urandom_range(0, 3));
         for (int k = 0; k < seg_len; k++) begin
            @(negedge clock);
            if (hold_req && !hold_done) begin
               rsp_stall <= 1'b1;
               for (int h = 1; h < HOLD_CYCLES; h++) @(negedge clock);
               hold_done = 1'b1;
            end else begin
               case (kind)
                  STALL_NONE:     rsp_stall <= 1'b0;
                  STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
                  STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
                  STALL_PERIODIC: rsp_stall <= (k % period == 0);
                  default:        rsp_stall <= 1'b0;
               endcase
            end
         end
      end
   end

   task automatic offer(input logic [lbp_pkg::MODE_W-1:0] mode,
                        input logic [lbp_pkg::DATA_W-1:0] data,
                        input int exp_n, input logic [lbp_pkg::BYTE_W-1:0] exp_byte);
      @(negedge clock);
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_data_value <= data;
      row_exp_n    = exp_n;
      row_exp_byte = exp_byte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_gap(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void pick_item(input mix_type mix,
                                     output logic [lbp_pkg::MODE_W-1:0] mode,
                                     output logic [lbp_pkg::DATA_W-1:0] data);
      int p;
      p = $urandom_range(0, 99);
      case (mix)
         MIX_BITS:
            mode = (p < 80) ? lbp_pkg::MODE_BIT : (p < 90) ? lbp_pkg::MODE_BYTE :
                   (p < 95) ? lbp_pkg::MODE_FLUSH : lbp_pkg::MODE_WORD16;
         MIX_WIDE:
            mode = (p < 40) ? lbp_pkg::MODE_WORD64 : (p < 70) ? lbp_pkg::MODE_WORD32 :
                   (p < 85) ? lbp_pkg::MODE_WORD16 : (p < 95) ? lbp_pkg::MODE_BYTE :
                   lbp_pkg::MODE_FLUSH;
         default:
            mode = (p < 25) ? lbp_pkg::MODE_BIT : (p < 45) ? lbp_pkg::MODE_BYTE :
                   (p < 57) ? lbp_pkg::MODE_WORD16 : (p < 69) ? lbp_pkg::MODE_WORD32 :
                   (p < 81) ? lbp_pkg::MODE_WORD64 : (p < 93) ? lbp_pkg::MODE_FLUSH :
                   (p < 96) ? MODE_SPARE6 : MODE_SPARE7;
      endcase
      p = $urandom_range(0, 9);
      data = (p == 0) ? ALL_ONES : (p == 1) ? '0 : {$urandom, $urandom};
   endfunction

   initial begin : timeout
      #(LIMIT_TIME);
      $display("lsb_first_bit_packer verification failed");
      $finish;
   end

   initial begin : stimulus
      logic [lbp_pkg::MODE_W-1:0] m;
      logic [lbp_pkg::DATA_W-1:0] d;
      int                         random_taken;
      int                         burst;
      mix_type                    mix;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = lbp_pkg::MODE_BIT;
      req_data_value = '0;
      random_taken   = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[r]) begin
         if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 4));
         offer(stim_table[r].mode, stim_table[r].data,
               stim_table[r].exp_n, stim_table[r].exp_byte);
      end
      settle();

      // long rsp hold while req keeps offering, so the store backs up
      hold_req = 1'b1;
      for (int k = 0; k < PRESS_ITEMS; k++) begin
         offer(lbp_pkg::MODE_WORD32, {$urandom, $urandom}, USE_MODEL, 8'h00);
      end
      settle();

      while (random_taken < RANDOM_ITEMS) begin
         mix   = mix_type'($urandom_range(0, 2));
         burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
         for (int k = 0; k < burst && random_taken < RANDOM_ITEMS; k++) begin
            pick_item(mix, m, d);
            offer(m, d, USE_MODEL, 8'h00);
            random_taken++;
         end
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
      end
      settle();

      $display("covered %0d req transfers and %0d checked bytes", items_taken, bytes_checked);
      $display("in %0d drains, %0d of them full", drains_seen, full_drains);
      if (fail_count == 0) begin
         $display("lsb_first_bit_packer verification clean");
      end else begin
         $display("lsb_first_bit_packer verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
